FILE: design/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg: shared definitions for the streaming 3x3 convolution core
// Field widths, register indexes, default sizes and the output queue status
// record used between the top level and its result queue.
// ----------------------------------------------------------------------------
package c2d_pkg;

   // Default values of the top level parameters.
   localparam int DEF_MAX_WIDTH   = 64;
   localparam int DEF_PIXEL_BITS  = 16;
   localparam int DEF_WEIGHT_BITS = 16;

   // Kernel size and frame limits.
   localparam int KSIZE      = 3;
   localparam int MIN_DIM    = 3;
   localparam int MAX_HEIGHT = 4096;
   localparam int RESET_DIM  = 6;

   // Fixed widths of registers and result fields.
   localparam int KERNEL_BITS    = 48;
   localparam int WIDTH_REG_BITS = 7;
   localparam int HEIGHT_BITS    = 13;
   localparam int ROW_BITS       = 12;
   localparam int FEAT_BITS      = 36;
   localparam int CSR_DATA_BITS  = 48;
   localparam int CSR_INDEX_BITS = 3;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KERNEL_TOP   = 3'd0,
      CSR_KERNEL_MID   = 3'd1,
      CSR_KERNEL_BOT   = 3'd2,
      CSR_FRAME_WIDTH  = 3'd3,
      CSR_FRAME_HEIGHT = 3'd4
   } csr_index_type;

   // Result queue sizing.
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                 not_empty;
      logic [QCNT_BITS-1:0] count;
   } queue_status_type;

endpackage

FILE: design/c2d_ram.sv
// ----------------------------------------------------------------------------
// c2d_ram: generic single write port RAM with registered read
// One write and one read per cycle; read data appears after the clock edge.
// ----------------------------------------------------------------------------
module c2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/c2d_cell.sv
// ----------------------------------------------------------------------------
// c2d_cell: one window column of the convolution
// Holds one three-pixel column of the window, hands it on to the next cell
// when the window shifts, and forms the weighted sum of its column.
// ----------------------------------------------------------------------------
module c2d_cell import c2d_pkg::*; #(
   parameter int PIXEL_BITS  = DEF_PIXEL_BITS,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic [KSIZE*PIXEL_BITS-1:0]   col_in,
   input  logic [KSIZE*WEIGHT_BITS-1:0]  weights,
   output logic [KSIZE*PIXEL_BITS-1:0]   col_out,
   output logic signed [FEAT_BITS-1:0]   col_sum
);

   localparam int PROD_BITS = PIXEL_BITS + WEIGHT_BITS;
   localparam int EXT_BITS  = (PROD_BITS > FEAT_BITS) ? PROD_BITS : FEAT_BITS;

   logic [KSIZE*PIXEL_BITS-1:0] column_ff, column_in;
   logic signed [FEAT_BITS-1:0] prod_ff [KSIZE];
   logic signed [FEAT_BITS-1:0] prod_in [KSIZE];
   logic signed [FEAT_BITS-1:0] col_sum_ff, col_sum_in;

   always_comb begin
      column_in = shift_en ? col_in : column_ff;
   end

   // Products are taken modulo 2^FEAT_BITS, which is all the result keeps.
   always_comb begin
      logic signed [PROD_BITS-1:0] prod_full;
      logic signed [EXT_BITS-1:0]  prod_ext;
      for (int i = 0; i < KSIZE; i++) begin
         prod_full  = $signed(column_ff[i*PIXEL_BITS +: PIXEL_BITS]) *
                      $signed(weights[i*WEIGHT_BITS +: WEIGHT_BITS]);
         prod_ext   = EXT_BITS'(prod_full);
         prod_in[i] = prod_ext[FEAT_BITS-1:0];
      end
   end

   always_comb begin
      col_sum_in = '0;
      for (int i = 0; i < KSIZE; i++) begin
         col_sum_in = col_sum_in + prod_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else begin
         column_ff <= column_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < KSIZE; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      col_sum_ff <= col_sum_in;
   end

   assign col_out = column_ff;
   assign col_sum = col_sum_ff;

endmodule

FILE: design/c2d_queue.sv
// ----------------------------------------------------------------------------
// c2d_queue: result queue in front of the output channel
// A small register FIFO that absorbs the beats still in the pipeline while
// the receiver stalls.
// ----------------------------------------------------------------------------
module c2d_queue import c2d_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   logic [WIDTH-1:0]     slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data         = slots_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.count     = count_ff;

endmodule

FILE: design/conv2d_3x3_valid_stream_core.sv
// ----------------------------------------------------------------------------
// conv2d_3x3_valid_stream_core: streaming 3x3 convolution, valid region
// Raster-order pixels in, one window sum out for every pixel at row and
// column two or more, with its output position and an end-of-frame mark.
// ----------------------------------------------------------------------------
// The core takes one pixel beat every clock cycle and keeps that rate for as
// long as the result side does not stall. A result reaches the rsp_ side
// after the registered read of the line store, which keeps the two rows
// above, the window shift into the three column cells, their multipliers,
// the column sums and the final add into the result queue, in that order.
// The queue holds eight results; req_stall rises when the queued results
// and those still in the pipeline fill it. The line store needs no clearing
// after reset: a valid flag per column makes unwritten entries read as
// zero, so pixels are accepted straight after reset. Registers are to be
// written only while no beat is in flight.
module conv2d_3x3_valid_stream_core import c2d_pkg::*; #(
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int PIXEL_BITS  = DEF_PIXEL_BITS,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration port.
   input  logic                           csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]       csr_wdata,
   // Pixel channel.
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [PIXEL_BITS-1:0]   req_pixel_value,
   // Result channel.
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [FEAT_BITS-1:0]    rsp_feature_value,
   output logic [ROW_BITS-1:0]            rsp_out_row,
   output logic [$clog2(MAX_WIDTH)-1:0]   rsp_out_col,
   output logic                           rsp_frame_last
);

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int CW        = (COL_BITS + 1 > WIDTH_REG_BITS) ? COL_BITS + 1 : WIDTH_REG_BITS;
   localparam int META_BITS = ROW_BITS + COL_BITS + 1;
   localparam int QW        = FEAT_BITS + META_BITS;
   localparam int COLV_BITS = KSIZE * PIXEL_BITS;
   localparam int WGT_BITS  = KSIZE * WEIGHT_BITS;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [KERNEL_BITS-1:0]    kern_top_ff, kern_mid_ff, kern_bot_ff;
   logic [WIDTH_REG_BITS-1:0] fwidth_ff;
   logic [HEIGHT_BITS-1:0]    fheight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kern_top_ff <= '0;
         kern_mid_ff <= '0;
         kern_bot_ff <= '0;
         fwidth_ff   <= WIDTH_REG_BITS'(RESET_DIM);
         fheight_ff  <= HEIGHT_BITS'(RESET_DIM);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KERNEL_TOP:   kern_top_ff <= csr_wdata[KERNEL_BITS-1:0];
            CSR_KERNEL_MID:   kern_mid_ff <= csr_wdata[KERNEL_BITS-1:0];
            CSR_KERNEL_BOT:   kern_bot_ff <= csr_wdata[KERNEL_BITS-1:0];
            CSR_FRAME_WIDTH:  fwidth_ff   <= csr_wdata[WIDTH_REG_BITS-1:0];
            CSR_FRAME_HEIGHT: fheight_ff  <= csr_wdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Frame size in use, clamped into the supported range.
   logic [CW-1:0]          fw_ext, eff_w;
   logic [HEIGHT_BITS-1:0] eff_h;

   always_comb begin
      fw_ext = CW'(fwidth_ff);
      if (fw_ext < CW'(MIN_DIM)) begin
         eff_w = CW'(MIN_DIM);
      end else if (fw_ext > CW'(MAX_WIDTH)) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = fw_ext;
      end
      if (fheight_ff < HEIGHT_BITS'(MIN_DIM)) begin
         eff_h = HEIGHT_BITS'(MIN_DIM);
      end else if (fheight_ff > HEIGHT_BITS'(MAX_HEIGHT)) begin
         eff_h = HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         eff_h = fheight_ff;
      end
   end

   // ------------------------------------------------------------------
   // Raster position of the incoming beat
   // ------------------------------------------------------------------
   logic [COL_BITS-1:0]    col_pos_ff, col_pos_in;
   logic [ROW_BITS-1:0]    row_pos_ff, row_pos_in;
   logic [CW-1:0]          c_adj, c_next;
   logic [HEIGHT_BITS-1:0] r_step, r_adj, r_next;
   logic                   pos_emit, pos_last;
   logic                   req_accept;

   // A position left past a smaller frame size folds into the next row or
   // into a new frame before the beat is placed.
   always_comb begin
      if (CW'(col_pos_ff) >= eff_w) begin
         c_adj  = '0;
         r_step = HEIGHT_BITS'(row_pos_ff) + HEIGHT_BITS'(1);
      end else begin
         c_adj  = CW'(col_pos_ff);
         r_step = HEIGHT_BITS'(row_pos_ff);
      end
      r_adj    = (r_step >= eff_h) ? '0 : r_step;
      pos_emit = (r_adj >= HEIGHT_BITS'(2)) && (c_adj >= CW'(2));
      pos_last = (r_adj == eff_h - HEIGHT_BITS'(1)) && (c_adj == eff_w - CW'(1));

      c_next = c_adj + CW'(1);
      r_next = r_adj;
      if (c_next >= eff_w) begin
         c_next = '0;
         r_next = r_adj + HEIGHT_BITS'(1);
         if (r_next >= eff_h) begin
            r_next = '0;
         end
      end
      col_pos_in = req_accept ? c_next[COL_BITS-1:0] : col_pos_ff;
      row_pos_in = req_accept ? r_next[ROW_BITS-1:0] : row_pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

   // ------------------------------------------------------------------
   // Line store: two rows above, packed as {row above by two, row above}
   // ------------------------------------------------------------------
   logic                       s1_valid_ff, s1_emit_ff, s1_lvld_ff;
   logic signed [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [COL_BITS-1:0]        s1_col_ff;
   logic [META_BITS-1:0]       s1_meta_ff;
   logic [MAX_WIDTH-1:0]       line_vld_ff;
   logic [2*PIXEL_BITS-1:0]    line_rd_data, line_wr_data;
   logic [PIXEL_BITS-1:0]      above2, above1;
   logic [COLV_BITS-1:0]       cur_col;
   logic [COL_BITS-1:0]        rd_col;

   assign rd_col = c_adj[COL_BITS-1:0];

   c2d_ram #(
      .WIDTH (2 * PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr_data),
      .rd_en   (req_accept),
      .rd_addr (rd_col),
      .rd_data (line_rd_data)
   );

   always_comb begin
      above2       = s1_lvld_ff ? line_rd_data[2*PIXEL_BITS-1:PIXEL_BITS] : '0;
      above1       = s1_lvld_ff ? line_rd_data[PIXEL_BITS-1:0] : '0;
      cur_col      = {s1_pixel_ff, above1, above2};
      line_wr_data = {above1, s1_pixel_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_vld_ff <= '0;
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else begin
         if (s1_valid_ff) begin
            line_vld_ff[s1_col_ff] <= 1'b1;
         end
         s1_valid_ff <= req_accept;
         s1_emit_ff  <= req_accept && pos_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_lvld_ff  <= line_vld_ff[rd_col];
         s1_pixel_ff <= req_pixel_value;
         s1_col_ff   <= rd_col;
         s1_meta_ff  <= {ROW_BITS'(r_adj - HEIGHT_BITS'(2)),
                         COL_BITS'(c_adj - CW'(2)), pos_last};
      end
   end

   // ------------------------------------------------------------------
   // Window: three column cells, the newest column enters on the right
   // ------------------------------------------------------------------
   logic [WGT_BITS-1:0]         cell_wt [KSIZE];
   logic signed [FEAT_BITS-1:0] cell_sum [KSIZE];
   logic [COLV_BITS-1:0]        col_centre, col_left;

   always_comb begin
      for (int k = 0; k < KSIZE; k++) begin
         cell_wt[k] = {kern_bot_ff[k*WEIGHT_BITS +: WEIGHT_BITS],
                       kern_mid_ff[k*WEIGHT_BITS +: WEIGHT_BITS],
                       kern_top_ff[k*WEIGHT_BITS +: WEIGHT_BITS]};
      end
   end

   c2d_cell #(
      .PIXEL_BITS  (PIXEL_BITS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_cell_right (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_valid_ff),
      .col_in   (cur_col),
      .weights  (cell_wt[2]),
      .col_out  (col_centre),
      .col_sum  (cell_sum[2])
   );

   c2d_cell #(
      .PIXEL_BITS  (PIXEL_BITS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_cell_centre (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_valid_ff),
      .col_in   (col_centre),
      .weights  (cell_wt[1]),
      .col_out  (col_left),
      .col_sum  (cell_sum[1])
   );

   c2d_cell #(
      .PIXEL_BITS  (PIXEL_BITS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_cell_left (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_valid_ff),
      .col_in   (col_left),
      .weights  (cell_wt[0]),
      .col_out  (),
      .col_sum  (cell_sum[0])
   );

   // ------------------------------------------------------------------
   // Position and end-of-frame mark travel alongside the cell pipeline
   // ------------------------------------------------------------------
   logic                 emit_a_ff, emit_b_ff, emit_c_ff;
   logic [META_BITS-1:0] meta_a_ff, meta_b_ff, meta_c_ff;
   logic signed [FEAT_BITS-1:0] feat_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_a_ff <= 1'b0;
         emit_b_ff <= 1'b0;
         emit_c_ff <= 1'b0;
      end else begin
         emit_a_ff <= s1_emit_ff;
         emit_b_ff <= emit_a_ff;
         emit_c_ff <= emit_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      meta_a_ff <= s1_meta_ff;
      meta_b_ff <= meta_a_ff;
      meta_c_ff <= meta_b_ff;
   end

   assign feat_sum = cell_sum[0] + cell_sum[1] + cell_sum[2];

   // ------------------------------------------------------------------
   // Result queue and flow control
   // ------------------------------------------------------------------
   queue_status_type      q_status;
   logic [QW-1:0]         q_out;
   logic [2:0]            inflight;
   logic [QCNT_BITS:0]    pending;
   logic                  rsp_accept;

   c2d_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit_c_ff),
      .push_data ({feat_sum, meta_c_ff}),
      .pop       (rsp_accept),
      .pop_data  (q_out),
      .status    (q_status)
   );

   // Every beat that will produce a result has a queue slot reserved for it.
   always_comb begin
      inflight = {2'b00, s1_emit_ff} + {2'b00, emit_a_ff} +
                 {2'b00, emit_b_ff} + {2'b00, emit_c_ff};
      pending  = (QCNT_BITS+1)'(q_status.count) + (QCNT_BITS+1)'(inflight);
   end

   assign req_stall  = (pending >= (QCNT_BITS+1)'(QUEUE_DEPTH));
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid         = q_status.not_empty;
   assign rsp_accept        = rsp_valid && !rsp_stall;
   assign rsp_feature_value = q_out[QW-1 -: FEAT_BITS];
   assign rsp_out_row       = q_out[META_BITS-1 -: ROW_BITS];
   assign rsp_out_col       = q_out[COL_BITS:1];
   assign rsp_frame_last    = q_out[0];

endmodule
